// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, suspended while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a property at every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/spa_pkg.sv -----
// ----------------------------------------------------------------------------
// spa_pkg
// Types and constants of the star projection and depth advance pipeline.
// ----------------------------------------------------------------------------
package spa_pkg;

    // Fixed-point format of depth and positions
    localparam int FRAC_BITS = 16;
    localparam logic [16:0] DEPTH_ONE = 17'(1) << FRAC_BITS;
    localparam logic [16:0] DEPTH_MAX = '1;

    // Brightness numerator: 0.2 * 255 = 51, scaled by 2^(2F)
    localparam int BRI_W = 42;
    localparam logic [BRI_W-1:0] BRI_NUM = BRI_W'(51) << (2 * FRAC_BITS);

    // Division steps: pixel quotients are 12 bits, brightness 8 bits
    localparam int DIV_STEPS = 12;
    localparam int BRI_STEPS = 8;
    localparam int STAGES    = DIV_STEPS + 2;

    // Register reset values
    localparam logic [11:0] WIDTH_RST  = 12'd320;
    localparam logic [11:0] HEIGHT_RST = 12'd256;
    localparam logic [11:0] FOCAL_RST  = 12'd128;
    localparam logic [7:0]  STEP_RST   = 8'd66;

    // Register indexes
    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_FOCAL  = 2'd2,
        CFG_STEP   = 2'd3
    } t_cfg_idx;

    // Products of the first stage
    typedef struct packed {
        logic signed [30:0] fx;
        logic signed [30:0] fy;
        logic [27:0]        hzx;
        logic [27:0]        hzy;
        logic [28:0]        szx;
        logic [28:0]        szy;
        logic [16:0]        z;
        logic [33:0]        zz;
        logic [15:0]        dm;
    } t_prod;

    // State of one division step
    typedef struct packed {
        logic [28:0]      rem_x;
        logic [28:0]      rem_y;
        logic [11:0]      qx;
        logic [11:0]      qy;
        logic [16:0]      dz;
        logic [BRI_W-1:0] rem_b;
        logic [33:0]      zz;
        logic [7:0]       qb;
        logic             sat;
        logic             vis;
        logic [16:0]      nd;
    } t_div;

endpackage

// ----- hw/rtl/star_project_and_advance_top.sv -----
// ----------------------------------------------------------------------------
// star_project_and_advance_top
// Perspective projection, brightness and depth advance of one star per word.
// ----------------------------------------------------------------------------
// Usage:
//   Star words enter on i_star_valid / o_star_ready (x, y, depth, frame ms).
//   Result words leave on o_res_valid / i_res_ready (pixel, visible,
//   brightness, next depth). Registers are written through i_cfg_we,
//   i_cfg_idx and i_cfg_data while no word is in flight.
//   Throughput: one word per cycle while results are taken. Stage one
//   forms all products, stage two the numerators, range tests and the
//   depth wrap, then twelve restoring-division steps give one quotient
//   bit per stage for both pixel coordinates; the last eight of them
//   also give the brightness. Each stage holds its word while the one
//   after it is full and stalled, so empty stages keep filling when the
//   receiver stops taking results; nothing is lost or repeated.
//   Reset empties the pipeline and loads the registers with width 320,
//   height 256, focal length 128 and depth step 66.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module star_project_and_advance_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [11:0]        i_cfg_data,
    // star words
    input  logic               i_star_valid,
    output logic               o_star_ready,
    input  logic signed [17:0] i_star_x,
    input  logic signed [17:0] i_star_y,
    input  logic [16:0]        i_star_depth,
    input  logic [7:0]         i_frame_ms,
    // result words
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [11:0]        o_pixel_x,
    output logic [11:0]        o_pixel_y,
    output logic               o_visible,
    output logic [7:0]         o_brightness,
    output logic [16:0]        o_next_depth
);
    import spa_pkg::*;

    logic [11:0]       r_width;
    logic [11:0]       r_height;
    logic [11:0]       r_focal;
    logic [7:0]        r_step;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] w_adv;
    t_prod             r_s1;
    t_prod             n_s1;
    t_div              r_dv [0:DIV_STEPS];
    t_div              n_dv [0:DIV_STEPS];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_focal  <= FOCAL_RST;
            r_step   <= STEP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_FOCAL:  r_focal  <= i_cfg_data;
                CFG_STEP:   r_step   <= i_cfg_data[7:0];
            endcase
        end
    end

    // Advance a stage when it is empty or the next one advances
    assign w_adv[STAGES-1] = !r_v[STAGES-1] || i_res_ready;
    for (genvar j = 0; j < STAGES - 1; j++) begin : g_adv
        assign w_adv[j] = !r_v[j] || w_adv[j+1];
    end

    // Move valid bits along the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_star_valid;
            end
            for (int j = 1; j < STAGES; j++) begin
                if (w_adv[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    // Stage one: form all products
    always_comb begin
        logic signed [30:0] w_focal_s;
        logic signed [30:0] w_x_s;
        logic signed [30:0] w_y_s;
        w_focal_s = 31'(r_focal);
        w_x_s     = 31'(i_star_x);
        w_y_s     = 31'(i_star_y);
        n_s1.fx   = w_focal_s * w_x_s;
        n_s1.fy   = w_focal_s * w_y_s;
        n_s1.hzx  = 28'(r_width[11:1]) * 28'(i_star_depth);
        n_s1.hzy  = 28'(r_height[11:1]) * 28'(i_star_depth);
        n_s1.szx  = 29'(r_width) * 29'(i_star_depth);
        n_s1.szy  = 29'(r_height) * 29'(i_star_depth);
        n_s1.z    = i_star_depth;
        n_s1.zz   = 34'(i_star_depth) * 34'(i_star_depth);
        n_s1.dm   = 16'(r_step) * 16'(i_frame_ms);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s1 <= n_s1;
        end
    end

    // Stage two: numerators, raster test, saturation test and depth wrap
    always_comb begin
        logic signed [31:0] w_num_x;
        logic signed [31:0] w_num_y;
        logic               w_in_x;
        logic               w_in_y;
        logic signed [18:0] w_d0;
        logic signed [18:0] w_d1;
        logic signed [18:0] w_d2;
        w_num_x = 32'(r_s1.fx) + $signed(32'(r_s1.hzx));
        w_num_y = 32'(r_s1.fy) + $signed(32'(r_s1.hzy));
        w_in_x  = (w_num_x >= $signed(32'(r_s1.z))) && (w_num_x < $signed(32'(r_s1.szx)));
        w_in_y  = (w_num_y >= $signed(32'(r_s1.z))) && (w_num_y < $signed(32'(r_s1.szy)));

        n_dv[0].vis   = (r_s1.z != '0) && w_in_x && w_in_y;
        n_dv[0].rem_x = n_dv[0].vis ? w_num_x[28:0] : '0;
        n_dv[0].rem_y = n_dv[0].vis ? w_num_y[28:0] : '0;
        n_dv[0].qx    = '0;
        n_dv[0].qy    = '0;
        n_dv[0].dz    = r_s1.z;

        // quotient of 256 or more saturates; zero depth saturates too
        n_dv[0].sat   = (r_s1.z == '0) || ({r_s1.zz, 8'd0} <= BRI_NUM);
        n_dv[0].rem_b = n_dv[0].sat ? '0 : BRI_NUM;
        n_dv[0].zz    = r_s1.zz;
        n_dv[0].qb    = '0;

        // wrap the advanced depth once into (0, 1]
        w_d0 = $signed(19'(r_s1.z)) - $signed(19'(r_s1.dm));
        w_d1 = (w_d0 <= 0) ? w_d0 + $signed(19'(DEPTH_ONE)) : w_d0;
        w_d2 = (w_d1 > $signed(19'(DEPTH_ONE))) ? w_d1 - $signed(19'(DEPTH_ONE)) : w_d1;
        if (w_d2 < 0) begin
            n_dv[0].nd = '0;
        end else if (w_d2 > $signed(19'(DEPTH_MAX))) begin
            n_dv[0].nd = DEPTH_MAX;
        end else begin
            n_dv[0].nd = w_d2[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_dv[0] <= n_dv[0];
        end
    end

    // Division steps: one quotient bit per stage, most significant first
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        localparam int B = DIV_STEPS - k;

        always_comb begin
            logic [28:0]      w_tx;
            logic [28:0]      w_ty;
            logic [BRI_W-1:0] w_tb;
            logic             w_take_x;
            logic             w_take_y;
            logic             w_take_b;
            w_tx     = 29'(r_dv[k-1].dz) << B;
            w_ty     = 29'(r_dv[k-1].dz) << B;
            w_tb     = BRI_W'(r_dv[k-1].zz) << B;
            // hidden stars keep a zero pixel quotient, zero depth included
            w_take_x = r_dv[k-1].vis && (r_dv[k-1].rem_x >= w_tx);
            w_take_y = r_dv[k-1].vis && (r_dv[k-1].rem_y >= w_ty);
            // brightness quotient has only its low bits
            w_take_b = (B < BRI_STEPS) && (r_dv[k-1].rem_b >= w_tb);

            n_dv[k]       = r_dv[k-1];
            n_dv[k].rem_x = w_take_x ? r_dv[k-1].rem_x - w_tx : r_dv[k-1].rem_x;
            n_dv[k].rem_y = w_take_y ? r_dv[k-1].rem_y - w_ty : r_dv[k-1].rem_y;
            n_dv[k].rem_b = w_take_b ? r_dv[k-1].rem_b - w_tb : r_dv[k-1].rem_b;
            n_dv[k].qx    = {r_dv[k-1].qx[10:0], w_take_x};
            n_dv[k].qy    = {r_dv[k-1].qy[10:0], w_take_y};
            n_dv[k].qb    = {r_dv[k-1].qb[6:0], w_take_b};
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k+1]) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    // Drive the result word
    assign o_star_ready = w_adv[0];
    assign o_res_valid  = r_v[STAGES-1];
    assign o_pixel_x    = r_dv[DIV_STEPS].qx;
    assign o_pixel_y    = r_dv[DIV_STEPS].qy;
    assign o_visible    = r_dv[DIV_STEPS].vis;
    assign o_brightness = r_dv[DIV_STEPS].sat ? 8'hFF : r_dv[DIV_STEPS].qb;
    assign o_next_depth = r_dv[DIV_STEPS].nd;

    // Checks
    `ASSERT_CLK(a_accept_fills, (i_star_valid && o_star_ready) |=> r_v[0],
        "accepted word not held in stage one")
    `ASSERT_CLK(a_vis_in_raster,
        (o_res_valid && o_visible) |-> (o_pixel_x != '0 && o_pixel_x < r_width &&
            o_pixel_y != '0 && o_pixel_y < r_height),
        "visible pixel outside raster")
    `ASSERT_CLK(a_hidden_zero,
        (o_res_valid && !o_visible) |-> (o_pixel_x == '0 && o_pixel_y == '0),
        "hidden star with nonzero pixel")
    `ASSERT_CLK(a_depth_range,
        o_res_valid |-> (o_next_depth != '0 && o_next_depth <= DEPTH_ONE),
        "next depth outside (0, 1]")
    `ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> (r_v == '0),
        "pipeline not empty after reset")

endmodule
